### hw/rtl/cqu_pkg.sv
// Package for the circular queue with update.
// Holds word and code types, operation and status codes, and the default depth.
// No dependencies.
package cqu_pkg;

  localparam int WORD_W        = 32;
  localparam int DEPTH_DEFAULT = 8;

  typedef logic [1:0]        kind_t;
  typedef logic [1:0]        status_t;
  typedef logic [2:0]        slot_t;
  typedef logic [WORD_W-1:0] word_t;

  // Operation codes carried by a request transaction.
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_MODIFY = 2'd2;
  localparam kind_t KIND_READ   = 2'd3;

  // Status codes carried by a response transaction.
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_FULL     = 2'd1;
  localparam status_t STATUS_EMPTY    = 2'd2;
  localparam status_t STATUS_NOTFOUND = 2'd3;

endpackage

### hw/rtl/cqu_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on cqu_pkg for the payload types.
interface cqu_req_if
  import cqu_pkg::*;
();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic signed [31:0] value;
  logic signed [31:0] new_value;
  slot_t              slot_index;

  modport source (output valid, kind, value, new_value, slot_index, input ready);
  modport sink   (input valid, kind, value, new_value, slot_index, output ready);
endinterface

interface cqu_rsp_if
  import cqu_pkg::*;
();
  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [31:0] data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
endinterface

### hw/rtl/cqu_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module cqu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/circular_queue_with_update.sv
// Ring-buffer queue of DEPTH signed 32-bit words held in one RAM. After reset the
// block sweeps the RAM to zero, one entry a cycle, and takes no request until the
// sweep is done. Every request gives exactly one response. Insert, a read beyond
// the depth and every refused operation go straight to the result step; remove
// and read slot first pass through the fetch step for the registered RAM read;
// modify scans from slot zero, one slot a cycle through the single RAM read port,
// until the first match or the last slot. A new request is taken as soon as the
// previous one has reached the response register, even if that response is
// still waiting to be taken.
// Depends on cqu_pkg, cqu_if and cqu_ram.
module circular_queue_with_update
  import cqu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic   clk,
  input logic   rst,
  cqu_req_if.sink   req,
  cqu_rsp_if.source rsp
);

  localparam int          PW      = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]    state, state_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic          is_empty, is_empty_next;
  logic [PW-1:0] clr, clr_next;
  logic [PW-1:0] sc, sc_next;
  kind_t         op, op_next;
  word_t         match, match_next;
  word_t         repl, repl_next;
  status_t       res_status, res_status_next;
  word_t         res_data, res_data_next;
  logic          out_valid;
  status_t       out_status;
  word_t         out_data;
  logic          load_out;

  logic          we;
  logic [PW-1:0] waddr;
  word_t         wdata;
  logic [PW-1:0] raddr;
  word_t         rdata;

  logic          accept;
  logic          full;
  logic          in_range;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;

  cqu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Handshake and queue status.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = !is_empty && (head == tail);
  assign in_range  = (32'(req.slot_index) < DEPTH_W);
  assign head_inc  = (head == LAST) ? '0 : head + PW'(1);
  assign tail_inc  = (tail == LAST) ? '0 : tail + PW'(1);

  // Sequencer: decode the transaction, drive the RAM ports, update pointers.
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    is_empty_next   = is_empty;
    clr_next        = clr;
    sc_next         = sc;
    op_next         = op;
    match_next      = match;
    repl_next       = repl;
    res_status_next = res_status;
    res_data_next   = res_data;
    load_out        = 1'b0;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    raddr           = '0;

    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        if (clr == LAST) begin
          state_next = ST_IDLE;
        end else begin
          clr_next = clr + PW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_next         = req.kind;
          match_next      = req.value;
          repl_next       = req.new_value;
          res_status_next = STATUS_OK;
          res_data_next   = '0;
          state_next      = ST_RESULT;
          unique case (req.kind)
            KIND_INSERT: begin
              if (full) begin
                res_status_next = STATUS_FULL;
              end else begin
                we            = 1'b1;
                waddr         = tail;
                wdata         = req.value;
                tail_next     = tail_inc;
                is_empty_next = 1'b0;
              end
            end
            KIND_REMOVE: begin
              if (is_empty) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                raddr      = head;
                state_next = ST_FETCH;
              end
            end
            KIND_MODIFY: begin
              if (is_empty) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                raddr      = '0;
                sc_next    = '0;
                state_next = ST_SCAN;
              end
            end
            KIND_READ: begin
              // A slot beyond the depth reads as zero.
              if (in_range) begin
                raddr      = PW'(req.slot_index);
                state_next = ST_FETCH;
              end
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_FETCH: begin
        res_data_next = rdata;
        state_next    = ST_RESULT;
        // A remove clears the head slot; draining the queue rewinds both pointers.
        if (op == KIND_REMOVE) begin
          we    = 1'b1;
          waddr = head;
          if (head_inc == tail) begin
            is_empty_next = 1'b1;
            head_next     = '0;
            tail_next     = '0;
          end else begin
            head_next = head_inc;
          end
        end
      end

      ST_SCAN: begin
        // rdata holds slot sc; stop at the first equal word.
        if (rdata == match) begin
          we              = 1'b1;
          waddr           = sc;
          wdata           = repl;
          res_status_next = STATUS_OK;
          state_next      = ST_RESULT;
        end else if (sc == LAST) begin
          res_status_next = STATUS_NOTFOUND;
          state_next      = ST_RESULT;
        end else begin
          sc_next = sc + PW'(1);
          raddr   = sc + PW'(1);
        end
      end

      ST_RESULT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
      clr      <= '0;
      sc       <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      is_empty <= is_empty_next;
      clr      <= clr_next;
      sc       <= sc_next;
    end
  end

  // Transaction payload held while the operation runs.
  always_ff @(posedge clk) begin
    op         <= op_next;
    match      <= match_next;
    repl       <= repl_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
  end

  // Response register: decouples the response side from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_data   <= res_data;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;

  // An empty queue always has both pointers rewound to slot zero.
  a_empty_rewound: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head == '0) && (tail == '0))
    else $error("empty queue with pointers away from slot zero");

  // The modify scan never addresses a slot beyond the depth.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (32'(sc) < DEPTH_W))
    else $error("scan address beyond depth");

  // A remove only reaches the fetch step on a non-empty queue.
  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) && (op == KIND_REMOVE) |-> !is_empty)
    else $error("remove fetch on an empty queue");

endmodule
